// ===== rtl/core/rpcd_pkg.sv =====
// Region pixel change detector: shared types, constants and codes.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package rpcd_pkg;

  localparam int NUM_REGIONS    = 4;
  localparam int COUNT_WIDTH    = 24;
  localparam int REGION_SLOTS   = 4;
  localparam int ACTIVE_REGIONS = (NUM_REGIONS < REGION_SLOTS) ? NUM_REGIONS : REGION_SLOTS;
  localparam int RCNT_W         = 24;
  localparam int CFG_DATA_W     = 48;
  localparam int CFG_INDEX_W    = 3;
  localparam int NUM_W          = COUNT_WIDTH + 7;
  localparam int DIV_W          = (NUM_W > RCNT_W + 8) ? NUM_W : RCNT_W + 8;
  localparam int PCT_SCALE      = 100;
  localparam int RECIP3_MUL     = 683;
  localparam int RECIP3_SHIFT   = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_DIFF       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIFF_THR       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PCT_THR        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNTS_LOW     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNTS_HIGH    = 3'd5;

  localparam logic [1:0] FMT_GRAY = 2'd0;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_EOF   = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] prev_c0;
    logic [7:0] prev_c1;
    logic [7:0] prev_c2;
    logic [7:0] cur_c0;
    logic [7:0] cur_c1;
    logic [7:0] cur_c2;
    logic [3:0] region_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0] region_index;
    logic [7:0] change_percent;
    logic       met;
    logic       last;
  } out_item_t;

  // token handed from cell to cell
  typedef struct packed {
    logic                    valid;
    logic                    eof;
    logic [7:0]              diff;
    logic [REGION_SLOTS-1:0] mask;
  } tok_t;

  typedef struct packed {
    logic       done;
    logic [7:0] pct;
    logic       met;
  } div_res_t;

  typedef enum logic [2:0] {
    CTL_RUN,
    CTL_DRAIN,
    CTL_START,
    CTL_WAIT,
    CTL_OUT
  } ctl_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_STEP
  } div_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/rpcd_front.sv =====
// Front stage: per-pixel difference (gray or channel-sum / 3) and global gate.
// Depends on rpcd_pkg; feeds the first region cell.
`default_nettype none

module rpcd_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire rpcd_pkg::in_item_t item,
  input  wire logic [1:0]       pixel_format,
  input  wire logic [7:0]       min_diff,
  output rpcd_pkg::tok_t        tok
);
  import rpcd_pkg::*;

  logic [7:0]  gray_diff;
  logic [9:0]  sum_prev;
  logic [9:0]  sum_cur;
  logic [9:0]  sum_diff;
  logic [19:0] scaled;
  logic [7:0]  diff;
  logic [REGION_SLOTS-1:0] mask_gated;

  always_comb begin
    gray_diff = (item.prev_c0 >= item.cur_c0) ? item.prev_c0 - item.cur_c0
                                              : item.cur_c0 - item.prev_c0;
    sum_prev  = 10'(item.prev_c0) + 10'(item.prev_c1) + 10'(item.prev_c2);
    sum_cur   = 10'(item.cur_c0) + 10'(item.cur_c1) + 10'(item.cur_c2);
    sum_diff  = (sum_prev >= sum_cur) ? sum_prev - sum_cur : sum_cur - sum_prev;
    // divide by 3: exact for values up to 765
    scaled    = 20'(sum_diff) * 20'(RECIP3_MUL);
    diff      = (pixel_format == FMT_GRAY) ? gray_diff : scaled[RECIP3_SHIFT +: 8];
    mask_gated = (diff >= min_diff) ? REGION_SLOTS'(item.region_mask) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok.valid <= accept;
    end
    tok.eof  <= (item.func == FUNC_EOF);
    tok.diff <= diff;
    tok.mask <= mask_gated;
  end

endmodule

`default_nettype wire

// ===== rtl/core/rpcd_cell.sv =====
// One region cell: saturating hit counter, end-of-frame snapshot, token pass-on.
// Depends on rpcd_pkg; chained by the top level.
`default_nettype none

module rpcd_cell (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire rpcd_pkg::tok_t                    tok_in,
  input  wire logic [7:0]                        diff_thr,
  output rpcd_pkg::tok_t                         tok_out,
  output logic [rpcd_pkg::COUNT_WIDTH-1:0]       snap
);
  import rpcd_pkg::*;

  logic [COUNT_WIDTH-1:0] hits;
  logic                   hit;

  assign hit = tok_in.valid && !tok_in.eof && tok_in.mask[0] && (tok_in.diff >= diff_thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      hits          <= '0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      if (tok_in.valid && tok_in.eof) begin
        hits <= '0;
      end else if (hit && hits != '1) begin
        hits <= hits + 1'b1;
      end
    end
    if (tok_in.valid && tok_in.eof) begin
      snap <= hits;
    end
    tok_out.eof  <= tok_in.eof;
    tok_out.diff <= tok_in.diff;
    tok_out.mask <= tok_in.mask >> 1;
  end

endmodule

`default_nettype wire

// ===== rtl/core/rpcd_div.sv =====
// Percent unit: 100 * hits / count by restoring division, one bit per cycle,
// saturated at 255, with threshold compare. Depends on rpcd_pkg.
`default_nettype none

module rpcd_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rpcd_pkg::COUNT_WIDTH-1:0] hits,
  input  wire logic [rpcd_pkg::RCNT_W-1:0]   count,
  input  wire logic [7:0]                    thr,
  output rpcd_pkg::div_res_t                 res
);
  import rpcd_pkg::*;

  div_state_t        state;
  div_state_t        state_next;
  logic [DIV_W-1:0]  num;
  logic [RCNT_W-1:0] den;
  logic [7:0]        thr_q;
  logic [7:0]        quo;
  logic [2:0]        bitc;
  logic [DIV_W-1:0]  trial;
  logic              take;
  logic [7:0]        quo_next;
  logic              sat;

  always_comb begin
    trial    = DIV_W'(den) << bitc;
    take     = (num >= trial);
    quo_next = quo | (take ? 8'(1) << bitc : 8'd0);
    sat      = (num >= (DIV_W'(den) << 8));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE:  if (start) state_next = DIV_CHECK;
      DIV_CHECK: if (den == '0 || sat) state_next = DIV_IDLE;
                 else state_next = DIV_STEP;
      DIV_STEP:  if (bitc == 3'd0) state_next = DIV_IDLE;
      default:   state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.done <= 1'b0;
    end else begin
      res.done <= ((state == DIV_CHECK) && (den == '0 || sat)) ||
                  ((state == DIV_STEP) && bitc == 3'd0);
    end
    unique case (state)
      DIV_IDLE: begin
        if (start) begin
          num   <= DIV_W'(hits) * DIV_W'(PCT_SCALE);
          den   <= count;
          thr_q <= thr;
          quo   <= '0;
          bitc  <= 3'd7;
        end
      end
      DIV_CHECK: begin
        if (den == '0) begin
          res.pct <= 8'd0;
          res.met <= (thr_q == 8'd0);
        end else if (sat) begin
          res.pct <= 8'hff;
          res.met <= 1'b1;
        end
      end
      DIV_STEP: begin
        if (take) begin
          num <= num - trial;
        end
        quo  <= quo_next;
        bitc <= bitc - 3'd1;
        if (bitc == 3'd0) begin
          res.pct <= quo_next;
          res.met <= (quo_next >= thr_q);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/region_pixel_change_detector_top.sv =====
// Top level of the region pixel change detector: config registers, front stage,
// chain of region cells, percent unit and report sequencer. Depends on rpcd_pkg.
//
// Pixel transactions are taken one per cycle unless stalled and flow through a
// row of region cells, one cell per region, each holding that region's saturating
// hit count. An end-of-frame transaction stalls the input until all reports are
// out: it drains through the front register and the cell row, then each region's
// percent is computed in turn by a shared bit-serial divider, and the report
// waits in the output register until taken. Counters clear at end of frame.
`default_nettype none

module region_pixel_change_detector_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire rpcd_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output rpcd_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_we,
  input  wire logic [rpcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rpcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rpcd_pkg::*;

  logic [1:0]            pixel_format;
  logic [7:0]            min_diff;
  logic [31:0]           diff_thr;
  logic [31:0]           pct_thr;
  logic [CFG_DATA_W-1:0] counts_low;
  logic [CFG_DATA_W-1:0] counts_high;

  ctl_state_t state;
  ctl_state_t state_next;
  logic [1:0] ridx;
  logic       in_accept;
  logic       out_accept;
  logic       region_last;

  tok_t                   tok [0:ACTIVE_REGIONS];
  logic [COUNT_WIDTH-1:0] snaps [0:REGION_SLOTS-1];

  logic [CFG_DATA_W-1:0]  count_word;
  logic [RCNT_W-1:0]      region_cnt;
  div_res_t               div_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= '0;
      min_diff     <= '0;
      diff_thr     <= '0;
      pct_thr      <= '0;
      counts_low   <= '0;
      counts_high  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT: pixel_format <= cfg_data[1:0];
        REG_MIN_DIFF:     min_diff     <= cfg_data[7:0];
        REG_DIFF_THR:     diff_thr     <= cfg_data[31:0];
        REG_PCT_THR:      pct_thr      <= cfg_data[31:0];
        REG_COUNTS_LOW:   counts_low   <= cfg_data;
        REG_COUNTS_HIGH:  counts_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall   = (state != CTL_RUN);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign region_last = (ridx == 2'(ACTIVE_REGIONS - 1));

  rpcd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .item         (in_data),
    .pixel_format (pixel_format),
    .min_diff     (min_diff),
    .tok          (tok[0])
  );

  for (genvar r = 0; r < REGION_SLOTS; r++) begin : g_cell
    if (r < ACTIVE_REGIONS) begin : g_on
      rpcd_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .tok_in   (tok[r]),
        .diff_thr (diff_thr[8*r +: 8]),
        .tok_out  (tok[r+1]),
        .snap     (snaps[r])
      );
    end else begin : g_off
      assign snaps[r] = '0;
    end
  end

  always_comb begin
    count_word = ridx[1] ? counts_high : counts_low;
    region_cnt = ridx[0] ? count_word[2*RCNT_W-1:RCNT_W] : count_word[RCNT_W-1:0];
  end

  rpcd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == CTL_START),
    .hits  (snaps[ridx]),
    .count (region_cnt),
    .thr   (pct_thr[8*ridx +: 8]),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTL_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CTL_RUN:   if (in_accept && in_data.func == FUNC_EOF) state_next = CTL_DRAIN;
      CTL_DRAIN: if (tok[ACTIVE_REGIONS].valid && tok[ACTIVE_REGIONS].eof) begin
                   state_next = CTL_START;
                 end
      CTL_START: state_next = CTL_WAIT;
      CTL_WAIT:  if (div_res.done) state_next = CTL_OUT;
      CTL_OUT:   if (out_accept) state_next = region_last ? CTL_RUN : CTL_START;
      default:   state_next = CTL_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ridx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == CTL_DRAIN) begin
        ridx <= '0;
      end else if (state == CTL_OUT && out_accept) begin
        ridx <= ridx + 2'd1;
      end
      if (state == CTL_WAIT && div_res.done) begin
        out_valid <= 1'b1;
      end else if (out_accept) begin
        out_valid <= 1'b0;
      end
    end
    if (state == CTL_WAIT && div_res.done) begin
      out_data.region_index   <= ridx;
      out_data.change_percent <= div_res.pct;
      out_data.met            <= div_res.met;
      out_data.last           <= region_last;
    end
  end

endmodule

`default_nettype wire
